/* rtl/core/rllt_pkg.sv */
// ----------------------------------------------------------------------------
// rllt_pkg
// Shared types and constants for the run-length line table.
// ----------------------------------------------------------------------------
package rllt_pkg;

  localparam int LINE_DEPTH = 256;
  localparam int CODE_DEPTH = 4096;

  localparam int OFFSET_W = 12;
  localparam int LINE_W   = 16;
  localparam int IDX_W    = $clog2(LINE_DEPTH);
  localparam int CNT_W    = $clog2(LINE_DEPTH + 1);
  localparam int BCNT_W   = $clog2(CODE_DEPTH + 1);
  localparam int MEM_W    = OFFSET_W + LINE_W;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_BYTES_FULL = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

endpackage

/* rtl/core/rllt_mem.sv */
// ----------------------------------------------------------------------------
// rllt_mem
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rllt_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/run_length_line_table.sv */
// ----------------------------------------------------------------------------
// run_length_line_table
// Run-length table of source lines for an appended byte stream, with
// binary-search lookup of the line that covers a byte offset.
// ----------------------------------------------------------------------------
//
//  channel   ports                                        handshake
//  input     in_operation, in_line_number, in_query_offset start & !busy
//  result    out_found_line, out_status                   out_valid (1 cycle)
//
//  Append: result strobed the cycle after the accept, busy stays low.
//  Lookup: busy while it searches, one entry-RAM read and compare per cycle;
//  result strobed when the search ends.
//  The RAM read port sets the pace: one probe per cycle.
//  Reset clears the counters and the FSM; RAM contents stay undefined.
//  The receiver cannot stall; a new transaction is taken in the strobe cycle.
// ----------------------------------------------------------------------------
module run_length_line_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_line_number,
  input  logic [11:0] in_query_offset,
  output logic        out_valid,
  output logic [15:0] out_found_line,
  output logic [1:0]  out_status
);

  rllt_pkg::state_t state_r, state_nxt;

  logic [rllt_pkg::CNT_W-1:0]    entry_count_r;
  logic [rllt_pkg::BCNT_W-1:0]   byte_count_r;
  logic [rllt_pkg::LINE_W-1:0]   last_line_r;
  logic [rllt_pkg::LINE_W-1:0]   first_line_r;
  logic [rllt_pkg::CNT_W-1:0]    lo_r, hi_r;
  logic [rllt_pkg::IDX_W-1:0]    mid_r;
  logic [rllt_pkg::OFFSET_W-1:0] query_r;
  logic [rllt_pkg::LINE_W-1:0]   best_line_r;
  logic                          out_valid_r;
  logic [rllt_pkg::LINE_W-1:0]   out_line_r;
  rllt_pkg::status_t             out_status_r;

  logic accept, is_lookup, is_append;
  logic bytes_full, table_full, need_entry, wr_en;
  logic rd_en;
  logic [rllt_pkg::IDX_W-1:0] rd_addr;
  logic [rllt_pkg::MEM_W-1:0] rd_data;
  logic [rllt_pkg::OFFSET_W-1:0] rd_start;
  logic [rllt_pkg::LINE_W-1:0]   rd_line;
  logic go_right, cont, search_done;
  logic [rllt_pkg::CNT_W-1:0] lo_n, hi_n, mid_n;
  logic [rllt_pkg::LINE_W-1:0] best_n;

  assign busy      = (state_r != rllt_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign is_lookup = (rllt_pkg::op_t'(in_operation) == rllt_pkg::OP_LOOKUP);
  assign is_append = !is_lookup;

  // append checks; byte count full wins over table full
  assign bytes_full = (byte_count_r == rllt_pkg::BCNT_W'(rllt_pkg::CODE_DEPTH));
  assign table_full = (entry_count_r == rllt_pkg::CNT_W'(rllt_pkg::LINE_DEPTH));
  assign need_entry = (entry_count_r == '0) || (last_line_r != in_line_number);
  assign wr_en      = accept && is_append && !bytes_full && need_entry && !table_full;

  assign rd_start = rd_data[rllt_pkg::MEM_W-1 -: rllt_pkg::OFFSET_W];
  assign rd_line  = rd_data[rllt_pkg::LINE_W-1:0];

  // one halving step on the probe that just returned
  assign go_right = (query_r >= rd_start);
  assign lo_n     = go_right ? ({1'b0, mid_r} + rllt_pkg::CNT_W'(1)) : lo_r;
  assign hi_n     = go_right ? hi_r : {1'b0, mid_r};
  assign best_n   = go_right ? rd_line : best_line_r;
  assign cont     = (lo_n < hi_n);
  assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);

  rllt_mem #(
    .ADDR_W (rllt_pkg::IDX_W),
    .DATA_W (rllt_pkg::MEM_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count_r[rllt_pkg::IDX_W-1:0]),
    .wr_data ({byte_count_r[rllt_pkg::OFFSET_W-1:0], in_line_number}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rllt_pkg::S_IDLE: begin
        if (accept && is_lookup && (entry_count_r != '0)) begin
          state_nxt = rllt_pkg::S_SEARCH;
        end
      end
      rllt_pkg::S_SEARCH: begin
        if (!cont) begin
          state_nxt = rllt_pkg::S_IDLE;
        end
      end
      default: state_nxt = rllt_pkg::S_IDLE;
    endcase
  end

  // FSM outputs: RAM read control and search completion
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    search_done = 1'b0;
    unique case (state_r)
      rllt_pkg::S_IDLE: begin
        rd_en   = accept && is_lookup;
        rd_addr = rllt_pkg::IDX_W'(entry_count_r >> 1);
      end
      rllt_pkg::S_SEARCH: begin
        rd_en       = cont;
        rd_addr     = mid_n[rllt_pkg::IDX_W-1:0];
        search_done = !cont;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rllt_pkg::S_IDLE;
      entry_count_r <= '0;
      byte_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && (is_append || (entry_count_r == '0))) || search_done;
      if (wr_en) begin
        entry_count_r <= entry_count_r + rllt_pkg::CNT_W'(1);
      end
      if (accept && is_append && !bytes_full && (!need_entry || !table_full)) begin
        byte_count_r <= byte_count_r + rllt_pkg::BCNT_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_line_r <= in_line_number;
      if (entry_count_r == '0) begin
        first_line_r <= in_line_number;
      end
    end
    if (accept && is_lookup) begin
      lo_r        <= '0;
      hi_r        <= entry_count_r;
      mid_r       <= rllt_pkg::IDX_W'(entry_count_r >> 1);
      query_r     <= in_query_offset;
      best_line_r <= first_line_r;
    end else if (state_r == rllt_pkg::S_SEARCH) begin
      lo_r        <= lo_n;
      hi_r        <= hi_n;
      mid_r       <= mid_n[rllt_pkg::IDX_W-1:0];
      best_line_r <= best_n;
    end
    if (accept) begin
      out_line_r <= '0;
      if (is_lookup) begin
        out_status_r <= rllt_pkg::ST_EMPTY;
      end else if (bytes_full) begin
        out_status_r <= rllt_pkg::ST_BYTES_FULL;
      end else if (need_entry && table_full) begin
        out_status_r <= rllt_pkg::ST_TABLE_FULL;
      end else begin
        out_status_r <= rllt_pkg::ST_OK;
      end
    end else if (search_done) begin
      out_line_r   <= best_n;
      out_status_r <= rllt_pkg::ST_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found_line = out_line_r;
  assign out_status     = out_status_r;

  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while search still running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= rllt_pkg::CNT_W'(rllt_pkg::LINE_DEPTH))
    else $error("entry count beyond table depth");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= rllt_pkg::BCNT_W'(rllt_pkg::CODE_DEPTH))
    else $error("byte count beyond code depth");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rllt_pkg::S_SEARCH) |-> (lo_r < hi_r))
    else $error("search window empty while searching");

  a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_append) |=> out_valid)
    else $error("append transaction gave no result");

  a_empty_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_lookup && (entry_count_r == '0)) |=>
      (out_valid && (out_status == rllt_pkg::ST_EMPTY) && (out_found_line == '0)))
    else $error("empty table lookup not flagged");

endmodule

/* bench/rllt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllt_checker
// Watches both channels of the line table, keeps its own copy of the run
// table and byte count, and compares every strobed result in order.
// ----------------------------------------------------------------------------
module rllt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_line_number,
  input  logic [11:0] in_query_offset,
  input  logic        out_valid,
  input  logic [15:0] out_found_line,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          bytes_used,
  output logic [15:0] tail_line
);

  typedef struct packed {
    logic [rllt_pkg::LINE_W-1:0] line;
    rllt_pkg::status_t           status;
  } line_reply_t;

  logic [rllt_pkg::OFFSET_W-1:0] run_start [rllt_pkg::LINE_DEPTH];
  logic [rllt_pkg::LINE_W-1:0]   run_line  [rllt_pkg::LINE_DEPTH];
  int                            run_count;
  int                            byte_count;
  line_reply_t                   due_replies [$];
  int                            shown;

  // Apply one transaction to the shadow table and return the reply it owes.
  function automatic line_reply_t step_line_table(rllt_pkg::op_t op, logic [15:0] line,
                                                  logic [11:0] offset);
    line_reply_t r;
    int lo;
    int hi;
    int mid;
    int best;
    r.line   = '0;
    r.status = rllt_pkg::ST_OK;
    lo       = 0;
    best     = 0;
    if (op == rllt_pkg::OP_APPEND) begin
      // byte count full wins over table full
      if (byte_count >= rllt_pkg::CODE_DEPTH) begin
        r.status = rllt_pkg::ST_BYTES_FULL;
      end else if (run_count == 0 || run_line[run_count-1] != line) begin
        if (run_count >= rllt_pkg::LINE_DEPTH) begin
          r.status = rllt_pkg::ST_TABLE_FULL;
        end else begin
          run_start[run_count] = rllt_pkg::OFFSET_W'(byte_count);
          run_line[run_count]  = line;
          run_count++;
          byte_count++;
        end
      end else begin
        byte_count++;
      end
    end else if (run_count == 0) begin
      r.status = rllt_pkg::ST_EMPTY;
    end else begin
      hi = run_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (offset < run_start[mid]) begin
          hi = mid;
        end else begin
          best = mid;
          lo   = mid + 1;
        end
      end
      r.line = run_line[best];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    line_reply_t want;
    if (!rst_n) begin
      run_count  = 0;
      byte_count = 0;
      due_replies.delete();
      fail_count = 0;
      shown      = 0;
    end else begin
      // retire first: a result never belongs to a transaction taken this edge
      if (out_valid) begin
        if (due_replies.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            $display("%t: result with nothing due: line %0d status %0d",
                     $realtime, out_found_line, out_status);
            shown++;
          end
        end else begin
          want = due_replies.pop_front();
          if (out_found_line !== want.line || out_status !== want.status) begin
            fail_count++;
            if (shown < 10) begin
              $display("%t: mismatch: line exp %0d got %0d, status exp %0d got %0d",
                       $realtime, want.line, out_found_line, want.status, out_status);
              shown++;
            end
          end
        end
      end
      if (start && !busy)
        due_replies.push_back(step_line_table(rllt_pkg::op_t'(in_operation),
                                              in_line_number, in_query_offset));
    end
    pending    = due_replies.size();
    bytes_used = byte_count;
    tail_line  = (run_count == 0) ? '0 : run_line[run_count-1];
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the run-length line table: directed corner transactions,
// then a random mix of runs and lookups that fills the table. The checker
// beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1700;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [15:0] in_line_number;
  logic [11:0] in_query_offset;
  logic        out_valid;
  logic [15:0] out_found_line;
  logic [1:0]  out_status;

  int          fail_count;
  int          pending;
  int          bytes_used;
  logic [15:0] tail_line;
  int          stall_cycles;
  bit          idle_on;

  run_length_line_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_line_number  (in_line_number),
    .in_query_offset (in_query_offset),
    .out_valid       (out_valid),
    .out_found_line  (out_found_line),
    .out_status      (out_status)
  );

  rllt_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_line_number  (in_line_number),
    .in_query_offset (in_query_offset),
    .out_valid       (out_valid),
    .out_found_line  (out_found_line),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending         (pending),
    .bytes_used      (bytes_used),
    .tail_line       (tail_line)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_item(rllt_pkg::op_t op, logic [15:0] line, logic [11:0] offset);
    if (idle_on && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_line_number  <= line;
    in_query_offset <= offset;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_lookup();
    int top_off;
    top_off = (bytes_used > 4095) ? 4095 : bytes_used;
    if ($urandom_range(99) < 70)
      send_item(rllt_pkg::OP_LOOKUP, 16'($urandom), 12'($urandom_range(0, top_off)));
    else
      send_item(rllt_pkg::OP_LOOKUP, 16'($urandom), 12'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int pick;
    logic [15:0] new_line;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = rllt_pkg::OP_APPEND;
    in_line_number  = '0;
    in_query_offset = '0;
    idle_on         = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, extreme lines, repeats, run boundaries, offsets past the end
    send_item(rllt_pkg::OP_LOOKUP, 16'hffff, 12'd0);
    send_item(rllt_pkg::OP_LOOKUP, 16'h0000, 12'hfff);
    send_item(rllt_pkg::OP_APPEND, 16'h0000, 12'hfff);
    send_item(rllt_pkg::OP_APPEND, 16'h0000, 12'h000);
    send_item(rllt_pkg::OP_APPEND, 16'hffff, 12'h000);
    send_item(rllt_pkg::OP_APPEND, 16'hffff, 12'hfff);
    send_item(rllt_pkg::OP_APPEND, 16'hffff, 12'h000);
    send_item(rllt_pkg::OP_APPEND, 16'h0000, 12'h000);
    send_item(rllt_pkg::OP_APPEND, 16'h5a5a, 12'h000);
    send_item(rllt_pkg::OP_APPEND, 16'ha5a5, 12'h000);
    for (int k = 0; k < 9; k++)
      send_item(rllt_pkg::OP_LOOKUP, 16'h0000, 12'(k));
    send_item(rllt_pkg::OP_LOOKUP, 16'hffff, 12'hfff);

    // runs of repeated lines with new lines mixed in; fills the table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 500 && n < 900);
      pick    = $urandom_range(99);
      if (pick < 35) begin
        send_lookup();
      end else if (pick < 75) begin
        send_item(rllt_pkg::OP_APPEND, tail_line, 12'($urandom));
      end else begin
        case ($urandom_range(3))
          0:       new_line = 16'hffff;
          1:       new_line = 16'h0000;
          2:       new_line = tail_line ^ 16'h0001;
          default: new_line = 16'($urandom);
        endcase
        send_item(rllt_pkg::OP_APPEND, new_line, 12'($urandom));
      end
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
